/* rtl/mppf_pkg.sv */
// Shared types and constants for the multi-pattern position finder.
// No dependencies; imported by every module of the block.
package mppf_pkg;

	localparam int DEF_NUM_PATTERNS    = 8;
	localparam int DEF_MAX_PATTERN_LEN = 16;
	localparam int DEF_MAX_SEQ_LEN     = 65536;

	localparam int SLOT_W  = 3;
	localparam int START_W = 17;

	typedef logic [7:0] sym_t;

	typedef enum logic [1:0] {
		OP_LOAD_CHAR = 2'd0,
		OP_SET_LEN   = 2'd1,
		OP_SEQ_CHAR  = 2'd2,
		OP_NEW_SEQ   = 2'd3
	} op_t;

endpackage

/* rtl/multi_pattern_position_finder_core.sv */
// Top level of the multi-pattern position finder: input register, control and config.
// Depends on mppf_pkg, mppf_window, mppf_match and mppf_result.
//
// One input beat is accepted per cycle unless the input register is held. Each beat sits
// in the input register, where it updates the pattern table or the window and, for a
// sequence character, all patterns are compared with the window at once; matches land
// in the result register and leave one beat per matching slot, lowest slot first, tlast
// on the final one. Hits pass the input register, then the result register. A character
// with k matches holds the result register for k beats, so another matching character
// behind it waits in the input register for those beats; characters without matches and
// table or reset beats pass at full rate regardless. There is no clearing pass after
// reset. Beyond MAX_SEQ_LEN characters no matches are reported until a new-sequence beat.
module multi_pattern_position_finder_core import mppf_pkg::*; #(
	parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
	parameter int MAX_SEQ_LEN     = DEF_MAX_SEQ_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[2:0], char_index[6:3], pattern_length[11:7], symbol[19:12], zero fill
	input  logic [23:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// match_slot[2:0], start_position[19:3], zero fill
	output logic [23:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_SEQ_LEN + 2);

	logic              valid_s1;
	op_t               op_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [3:0]        cidx_s1;
	logic [4:0]        plen_s1;
	sym_t              sym_s1;
	logic              case_fold_q;

	sym_t                    win_next [MAX_PATTERN_LEN];
	logic [CNT_W-1:0]        cnt_next;
	logic                    cnt_ok;
	logic [NUM_PATTERNS-1:0] hit;
	logic [START_W-1:0]      starts [NUM_PATTERNS];
	logic                    res_free;
	logic                    adv;
	logic                    is_seq;
	logic [SLOT_W-1:0]       match_slot;
	logic [START_W-1:0]      start_position;

	assign is_seq   = (op_s1 == OP_SEQ_CHAR);
	// only a character with matches needs the result register
	assign adv      = valid_s1 && (!is_seq || (hit == '0) || res_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser);
			slot_s1 <= s_tdata[2:0];
			cidx_s1 <= s_tdata[6:3];
			plen_s1 <= s_tdata[11:7];
			sym_s1  <= s_tdata[19:12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_fold_q <= 1'b1;
		end else if (cfg_we) begin
			case_fold_q <= cfg_wdata;
		end
	end

	mppf_window #(
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN),
		.MAX_SEQ_LEN     (MAX_SEQ_LEN),
		.CNT_W           (CNT_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.case_fold (case_fold_q),
		.step      (adv && is_seq),
		.clear     (adv && (op_s1 == OP_NEW_SEQ)),
		.sym       (sym_s1),
		.win_next  (win_next),
		.cnt_next  (cnt_next),
		.cnt_ok    (cnt_ok)
	);

	mppf_match #(
		.NUM_PATTERNS    (NUM_PATTERNS),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN),
		.CNT_W           (CNT_W)
	) u_match (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_char        (adv && (op_s1 == OP_LOAD_CHAR)),
		.wr_len         (adv && (op_s1 == OP_SET_LEN)),
		.slot           (slot_s1),
		.char_index     (cidx_s1),
		.pattern_length (plen_s1),
		.sym            (sym_s1),
		.win            (win_next),
		.cnt            (cnt_next),
		.cnt_ok         (cnt_ok),
		.hit            (hit),
		.starts         (starts)
	);

	mppf_result #(
		.NUM_PATTERNS (NUM_PATTERNS)
	) u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (adv && is_seq && (hit != '0)),
		.hit            (hit),
		.starts         (starts),
		.free           (res_free),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.match_slot     (match_slot),
		.start_position (start_position),
		.m_tlast        (m_tlast)
	);

	assign m_tdata = {4'd0, start_position, match_slot};

endmodule

/* rtl/mppf_window.sv */
// Sequence side: shift window of recent characters and the saturating position count.
// Depends on mppf_pkg.
module mppf_window import mppf_pkg::*; #(
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
	parameter int MAX_SEQ_LEN     = DEF_MAX_SEQ_LEN,
	parameter int CNT_W           = $clog2(MAX_SEQ_LEN + 2)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             case_fold,
	input  logic             step,
	input  logic             clear,
	input  sym_t             sym,
	output sym_t             win_next [MAX_PATTERN_LEN],
	output logic [CNT_W-1:0] cnt_next,
	output logic             cnt_ok
);

	sym_t             win_q [MAX_PATTERN_LEN];
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		// fold ASCII a..z to upper case
		if (case_fold && (sym inside {[8'h61:8'h7a]})) begin
			win_next[0] = sym - 8'd32;
		end else begin
			win_next[0] = sym;
		end
		for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	always_comb begin
		if (cnt_q <= CNT_W'(MAX_SEQ_LEN)) begin
			cnt_next = cnt_q + 1'b1;
		end else begin
			cnt_next = cnt_q;
		end
		cnt_ok = (cnt_next <= CNT_W'(MAX_SEQ_LEN));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (clear) begin
			cnt_q <= '0;
			for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
				win_q[i] <= '0;
			end
		end else if (step) begin
			cnt_q <= cnt_next;
			win_q <= win_next;
		end
	end

endmodule

/* rtl/mppf_match.sv */
// Pattern table (characters and lengths) and the parallel compare against the window.
// Depends on mppf_pkg.
module mppf_match import mppf_pkg::*; #(
	parameter int NUM_PATTERNS    = DEF_NUM_PATTERNS,
	parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
	parameter int CNT_W           = 17
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_char,
	input  logic                    wr_len,
	input  logic [SLOT_W-1:0]       slot,
	input  logic [3:0]              char_index,
	input  logic [4:0]              pattern_length,
	input  sym_t                    sym,
	input  sym_t                    win [MAX_PATTERN_LEN],
	input  logic [CNT_W-1:0]        cnt,
	input  logic                    cnt_ok,
	output logic [NUM_PATTERNS-1:0] hit,
	output logic [START_W-1:0]      starts [NUM_PATTERNS]
);

	localparam int LEN_W   = $clog2(MAX_PATTERN_LEN + 1);
	localparam int WIN_W   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam int SIDX_W  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
	localparam int CIDX_W  = WIN_W;
	localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	sym_t             pat_q [NUM_PATTERNS][MAX_PATTERN_LEN];
	logic [LEN_W-1:0] len_q [NUM_PATTERNS];

	logic [SIDX_W-1:0] slot_idx;
	logic [CIDX_W-1:0] char_idx;
	logic [LEN_W-1:0]  len_sat;

	assign slot_idx = SIDX_W'(slot);
	assign char_idx = CIDX_W'(char_index);

	always_comb begin
		if (pattern_length > MAX_PATTERN_LEN) begin
			len_sat = LEN_W'(MAX_PATTERN_LEN);
		end else begin
			len_sat = LEN_W'(pattern_length);
		end
	end

	// pattern characters have no defined reset value
	always_ff @(posedge clk) begin
		if (wr_char && (slot < NUM_PATTERNS) && (char_index < MAX_PATTERN_LEN)) begin
			pat_q[slot_idx][char_idx] <= sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				len_q[s] <= '0;
			end
		end else if (wr_len && (slot < NUM_PATTERNS)) begin
			len_q[slot_idx] <= len_sat;
		end
	end

	// pattern char i lines up with window entry len-1-i (entry 0 is newest)
	always_comb begin
		logic [LEN_W-1:0] idx;
		logic             all_ok;
		logic [CMP_W-1:0] cnt_x;
		logic [CMP_W-1:0] len_x;
		cnt_x = CMP_W'(cnt);
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			all_ok = 1'b1;
			for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
				idx = len_q[s] - LEN_W'(i) - 1'b1;
				if (LEN_W'(i) < len_q[s]) begin
					if (pat_q[s][i] != win[idx[WIN_W-1:0]]) begin
						all_ok = 1'b0;
					end
				end
			end
			len_x     = CMP_W'(len_q[s]);
			hit[s]    = cnt_ok && (len_q[s] != '0) && (cnt_x >= len_x) && all_ok;
			starts[s] = START_W'(cnt_x - len_x + 1'b1);
		end
	end

endmodule

/* rtl/mppf_result.sv */
// Result register: holds one character's hit set and hands out one beat per hit slot.
// Depends on mppf_pkg.
module mppf_result import mppf_pkg::*; #(
	parameter int NUM_PATTERNS = DEF_NUM_PATTERNS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [NUM_PATTERNS-1:0] hit,
	input  logic [START_W-1:0]      starts [NUM_PATTERNS],
	output logic                    free,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [SLOT_W-1:0]       match_slot,
	output logic [START_W-1:0]      start_position,
	output logic                    m_tlast
);

	localparam int SEL_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

	logic [NUM_PATTERNS-1:0] mask_q;
	logic [START_W-1:0]      starts_q [NUM_PATTERNS];
	logic [SEL_W-1:0]        sel;
	logic [NUM_PATTERNS-1:0] rest;

	// lowest pending slot goes first
	always_comb begin
		sel = '0;
		for (int s = NUM_PATTERNS - 1; s >= 0; s--) begin
			if (mask_q[s]) begin
				sel = SEL_W'(s);
			end
		end
		rest = mask_q & ~(NUM_PATTERNS'(1) << sel);
	end

	assign m_tvalid       = |mask_q;
	assign match_slot     = SLOT_W'(sel);
	assign start_position = starts_q[sel];
	assign m_tlast        = (rest == '0);
	assign free           = !m_tvalid || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= hit;
		end else if (m_tvalid && m_tready) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			starts_q <= starts;
		end
	end

endmodule

/* verif/multi_pattern_position_finder_core_tb.sv */
`timescale 1ns / 100ps
// Testbench for multi_pattern_position_finder_core: directed and random streams of table,
// sequence and restart beats, each result beat checked against a behavioral predictor.
// Depends on mppf_pkg and the core RTL only.
module multi_pattern_position_finder_core_tb;
	import mppf_pkg::*;

	localparam int NP             = DEF_NUM_PATTERNS;
	localparam int PL             = DEF_MAX_PATTERN_LEN;
	localparam int SEQ_MAX        = DEF_MAX_SEQ_LEN;
	localparam int SETTLE         = 6;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RANDOM_ITEMS   = 120;

	localparam sym_t UPPER_A  = 8'h41;
	localparam sym_t UPPER_B  = 8'h42;
	localparam sym_t UPPER_Z  = 8'h5A;
	localparam sym_t LOWER_A  = 8'h61;
	localparam sym_t LOWER_B  = 8'h62;
	localparam sym_t LOWER_Z  = 8'h7A;
	localparam sym_t CASE_GAP = 8'h20;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [START_W-1:0] start;
		logic               last;
	} match_beat_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;

	// predictor state
	sym_t          pat_chars [NP][PL];
	logic [4:0]    pat_len [NP];
	logic [PL-1:0] pat_written [NP];
	sym_t          window [PL];
	int            seq_count;
	logic          fold_on;
	match_beat_t   pending_matches [$];

	int          errors     = 0;
	int          rx_count   = 0;
	int          rx_seen    = 0;
	int          rx_hold    = 0;
	int          beats_sent = 0;
	int          cycles     = 0;
	bit          tx_calm    = 1'b0;
	bit          rx_calm    = 1'b0;
	match_beat_t rx_want;

	multi_pattern_position_finder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("multi_pattern_position_finder_core_tb failed");
			$finish;
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			rx_count = rx_count + 1;
			if (pending_matches.size() == 0) begin
				$error("unexpected result beat: match_slot %0d start_position %0d",
					m_tdata[SLOT_W-1:0], m_tdata[SLOT_W +: START_W]);
				errors = errors + 1;
			end else begin
				rx_want = pending_matches.pop_front();
				if (m_tdata[SLOT_W-1:0] !== rx_want.slot) begin
					$error("match_slot: expected %0d, actual %0d",
						rx_want.slot, m_tdata[SLOT_W-1:0]);
					errors = errors + 1;
				end
				if (m_tdata[SLOT_W +: START_W] !== rx_want.start) begin
					$error("start_position: expected %0d, actual %0d",
						rx_want.start, m_tdata[SLOT_W +: START_W]);
					errors = errors + 1;
				end
				if (m_tlast !== rx_want.last) begin
					$error("last: expected %0d, actual %0d", rx_want.last, m_tlast);
					errors = errors + 1;
				end
			end
		end
	end

	// draw a fresh stall after every accepted result beat
	always @(negedge clk) begin
		if (rx_count != rx_seen) begin
			rx_seen = rx_count;
			rx_hold = rx_calm ? 0 : $urandom_range(0, 13);
		end
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold = rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic advance_finder(op_t op, logic [2:0] slot, logic [3:0] cidx,
			logic [4:0] plen, sym_t sym);
		match_beat_t found [$];
		match_beat_t mb;
		bit          hit;
		case (op)
		OP_LOAD_CHAR: begin
			pat_chars[slot][cidx]   = sym;
			pat_written[slot][cidx] = 1'b1;
		end
		OP_SET_LEN: begin
			pat_len[slot] = (plen > PL) ? 5'(PL) : plen;
		end
		OP_NEW_SEQ: begin
			for (int i = 0; i < PL; i++) window[i] = '0;
			seq_count = 0;
		end
		default: begin
			for (int i = PL - 1; i > 0; i--) window[i] = window[i-1];
			window[0] = (fold_on && sym >= LOWER_A && sym <= LOWER_Z) ? sym - CASE_GAP : sym;
			if (seq_count <= SEQ_MAX) seq_count++;
			// past the position limit the counter holds and nothing is reported
			if (seq_count <= SEQ_MAX) begin
				for (int s = 0; s < NP; s++) begin
					hit = (pat_len[s] != 0) && (seq_count >= pat_len[s]);
					for (int i = 0; i < pat_len[s]; i++)
						if (pat_chars[s][i] != window[pat_len[s] - 1 - i]) hit = 1'b0;
					if (hit) begin
						mb.slot  = SLOT_W'(s);
						mb.start = START_W'(seq_count - int'(pat_len[s]) + 1);
						mb.last  = 1'b0;
						found.push_back(mb);
					end
				end
				if (found.size() > 0) begin
					mb = found[found.size() - 1];
					mb.last = 1'b1;
					found[found.size() - 1] = mb;
				end
				foreach (found[i]) pending_matches.push_back(found[i]);
			end
		end
		endcase
	endtask

	task automatic send_beat(op_t op, logic [2:0] slot, logic [3:0] cidx,
			logic [4:0] plen, sym_t sym);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, sym, plen, cidx, slot};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		advance_finder(op, slot, cidx, plen, sym);
		beats_sent++;
	endtask

	// unused fields of a sequence beat carry random bits
	task automatic seq_char(sym_t c);
		send_beat(OP_SEQ_CHAR, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
			5'($urandom_range(0, 31)), c);
	endtask

	task automatic new_sequence();
		send_beat(OP_NEW_SEQ, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
			5'($urandom_range(0, 31)), sym_t'($urandom_range(0, 255)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_case_fold(bit v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		fold_on    = v;
	endtask

	// longest written prefix of a slot; a full slot takes any length field
	function automatic int written_prefix(int s);
		int n;
		n = 0;
		while (n < PL && pat_written[s][n]) n++;
		return (n == PL) ? 31 : n;
	endfunction

	function automatic sym_t pick_symbol();
		case ($urandom_range(0, 7))
		0, 1, 2: return UPPER_A;
		3, 4:    return UPPER_B;
		5:       return LOWER_A;
		6:       return LOWER_B;
		default: return sym_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_noise();
		op_t        op;
		logic [2:0] slot;
		logic [3:0] cidx;
		logic [4:0] plen;
		int         room;
		op   = op_t'($urandom_range(0, 3));
		slot = 3'($urandom_range(0, 7));
		cidx = 4'($urandom_range(0, 15));
		plen = 5'($urandom_range(0, 31));
		// keep lengths within written characters
		if (op == OP_SET_LEN) begin
			room = written_prefix(slot);
			if (plen > room) plen = 5'($urandom_range(0, room));
		end
		send_beat(op, slot, cidx, plen, sym_t'($urandom_range(0, 255)));
	endtask

	task automatic plant_pattern();
		int   s;
		int   k;
		sym_t c;
		s = $urandom_range(0, NP - 1);
		k = 0;
		while (pat_len[s] == 0 && k < NP) begin
			s = (s + 1) % NP;
			k++;
		end
		for (int i = 0; i < pat_len[s]; i++) begin
			c = pat_chars[s][i];
			if (fold_on && c >= UPPER_A && c <= UPPER_Z && $urandom_range(0, 1))
				c = c + CASE_GAP;
			seq_char(c);
		end
	endtask

	task automatic test_basic_matches();
		send_beat(OP_LOAD_CHAR, 3'd0, 4'd0, 5'd0, UPPER_A);
		send_beat(OP_SET_LEN, 3'd0, 4'd0, 5'd1, 8'h00);
		send_beat(OP_LOAD_CHAR, 3'd7, 4'd0, 5'd0, UPPER_A);
		send_beat(OP_LOAD_CHAR, 3'd7, 4'd1, 5'd0, UPPER_B);
		send_beat(OP_SET_LEN, 3'd7, 4'd0, 5'd2, 8'h00);
		new_sequence();
		seq_char(LOWER_A);
		seq_char(LOWER_B);
		seq_char(UPPER_A);
		seq_char(UPPER_B);
		seq_char(8'hFF);
		seq_char(8'h00);
	endtask

	// a pattern of zero bytes must wait until enough characters have arrived
	task automatic test_short_sequence();
		send_beat(OP_LOAD_CHAR, 3'd1, 4'd0, 5'd0, 8'h00);
		send_beat(OP_LOAD_CHAR, 3'd1, 4'd1, 5'd0, 8'h00);
		send_beat(OP_SET_LEN, 3'd1, 4'd0, 5'd2, 8'h00);
		new_sequence();
		seq_char(8'h00);
		seq_char(8'h00);
		seq_char(8'h00);
	endtask

	task automatic test_case_fold();
		set_case_fold(1'b0);
		send_beat(OP_LOAD_CHAR, 3'd2, 4'd0, 5'd0, LOWER_A);
		send_beat(OP_SET_LEN, 3'd2, 4'd0, 5'd1, 8'h00);
		seq_char(LOWER_A);
		seq_char(UPPER_A);
		set_case_fold(1'b1);
		seq_char(LOWER_A);
	endtask

	task automatic test_empty_slot();
		send_beat(OP_SET_LEN, 3'd0, 4'd0, 5'd0, 8'h00);
		seq_char(UPPER_A);
	endtask

	task automatic test_random_streams();
		int items0;
		int plen;
		int field;
		int slot;
		int pick;
		int phase;
		items0   = beats_sent;
		phase    = 0;
		while (beats_sent - items0 < RANDOM_ITEMS) begin
			if (phase > 0 && $urandom_range(0, 3) == 0)
				set_case_fold(1'($urandom_range(0, 1)));
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 2)) begin
				slot = $urandom_range(0, NP - 1);
				if (phase == 0)
					plen = PL;
				else if ($urandom_range(0, 3) == 0)
					plen = $urandom_range(5, PL);
				else
					plen = $urandom_range(1, 4);
				for (int i = 0; i < plen; i++)
					send_beat(OP_LOAD_CHAR, 3'(slot), 4'(i), 5'($urandom_range(0, 31)),
						pick_symbol());
				// a full pattern also takes lengths beyond the table limit
				field = (plen == PL) ? $urandom_range(phase == 0 ? PL + 1 : PL, 31) : plen;
				send_beat(OP_SET_LEN, 3'(slot), 4'($urandom_range(0, 15)), 5'(field),
					sym_t'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 4) != 0) new_sequence();
			repeat ($urandom_range(10, 30)) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					send_noise();
				else if (pick == 1)
					plant_pattern();
				else
					seq_char(pick_symbol());
			end
			// hold the sender until every match has drained
			if (phase == 0 || $urandom_range(0, 2) == 0) wait_idle();
			phase++;
		end
	endtask

	initial begin
		for (int s = 0; s < NP; s++) begin
			pat_len[s]     = '0;
			pat_written[s] = '0;
			for (int i = 0; i < PL; i++) pat_chars[s][i] = '0;
		end
		for (int i = 0; i < PL; i++) window[i] = '0;
		seq_count = 0;
		fold_on   = 1'b1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_matches();
		test_short_sequence();
		test_case_fold();
		test_empty_slot();
		test_random_streams();

		wait_idle();
		if (errors == 0) begin
			$display("multi_pattern_position_finder_core_tb passed");
		end else begin
			$display("multi_pattern_position_finder_core_tb failed");
		end
		$finish;
	end

endmodule
